// ----- hw/rtl/lfps_pkg.sv -----
// Shared types and constants for the line-follow PID steering block.
package lfps_pkg;

    localparam int MASK_W      = 12;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int SUM_W       = 16;
    localparam int CNT_W       = 5;
    localparam int DIVD_W      = 15;
    localparam int MCAND_W     = 24;
    localparam int MPLIER_W    = 17;
    localparam int PROD_W      = 41;
    localparam int ALPHA_ONE   = 32768;
    localparam int SPEED_MAX_Q = 25600;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P           = 4'd0,
        REG_GAIN_I           = 4'd1,
        REG_GAIN_D           = 4'd2,
        REG_BASE_SPEED       = 4'd3,
        REG_TRIM_OFFSET      = 4'd4,
        REG_POSITION_ALPHA   = 4'd5,
        REG_DERIVATIVE_ALPHA = 4'd6,
        REG_INTEGRAL_LIMIT   = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [6:0]         cruise_speed;
        logic signed [15:0] trim_offset;
        logic [15:0]        position_alpha;
        logic [15:0]        derivative_alpha;
        logic [14:0]        integral_limit;
    } cfg_t;

    typedef struct packed {
        logic               line_lost;
        logic [6:0]         drive_left;
        logic [6:0]         drive_right;
        logic signed [15:0] pid_output;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SUM,
        ST_CLAMP,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_POS,
        OP_P,
        OP_D,
        OP_DF,
        OP_I
    } mul_op_t;

endpackage

// ----- hw/rtl/line_follow_pid_steering.sv -----
// Top level: configuration registers, request channels and output register.
//
// Line-follow PID steering. Each request on the input channel carries a
// sensor mask; each one yields exactly one result request on the output
// channel (line_lost, drive_left, drive_right, pid_output).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no request is in flight.
// Datapath: the sensor mask is scanned one bit per cycle, the position mean
// comes from a 15-step serial divider, and the filters and PID run five
// multiplies on a 17-step bit-serial multiplier, four when the position
// filter restarts. When no sensor sees the line, the divider and the
// multiplies are skipped.
// One request is worked on at a time; in_ready is high only while the
// sequencer is idle.
// Output: a result register holds the last result; the sequencer may start
// the next request while it waits, and stalls at its end only if the
// receiver still holds the previous result.
// Reset: asynchronous, active low; registers return to their defaults and
// the controller state is cleared with the filter set to restart.
module line_follow_pid_steering import lfps_pkg::*;
#(
    parameter int SENSOR_COUNT = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MASK_W-1:0]      sensor_mask,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   line_lost,
    output logic [6:0]             drive_left,
    output logic [6:0]             drive_right,
    output logic signed [15:0]     pid_output
);

    localparam int WIDE_W = MASK_W + SENSOR_COUNT;

    cfg_t              cfg_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic [WIDE_W-1:0] mask_wide;
    logic              core_idle;
    logic              res_valid;
    logic              res_take;
    result_t           res;

    assign cfg_ready = 1'b1;

    // Register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p           <= 16'sd256;
            cfg_reg.gain_i           <= 16'sd0;
            cfg_reg.gain_d           <= 16'sd128;
            cfg_reg.cruise_speed     <= 7'd50;
            cfg_reg.trim_offset      <= 16'sd0;
            cfg_reg.position_alpha   <= 16'd6554;
            cfg_reg.derivative_alpha <= 16'd3277;
            cfg_reg.integral_limit   <= 15'd7680;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_GAIN_P:           cfg_reg.gain_p           <= cfg_data;
                REG_GAIN_I:           cfg_reg.gain_i           <= cfg_data;
                REG_GAIN_D:           cfg_reg.gain_d           <= cfg_data;
                REG_BASE_SPEED:       cfg_reg.cruise_speed     <= cfg_data[6:0];
                REG_TRIM_OFFSET:      cfg_reg.trim_offset      <= cfg_data;
                REG_POSITION_ALPHA:   cfg_reg.position_alpha   <= cfg_data;
                REG_DERIVATIVE_ALPHA: cfg_reg.derivative_alpha <= cfg_data;
                REG_INTEGRAL_LIMIT:   cfg_reg.integral_limit   <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    // Fit the mask to the sensor count
    assign mask_wide = WIDE_W'(sensor_mask);
    assign in_ready  = core_idle;

    lfps_core #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .mask      (mask_wide[SENSOR_COUNT-1:0]),
        .cfg       (cfg_reg),
        .idle      (core_idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // Load the result register when it is free or being drained
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
            out_res_reg   <= res;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_lost   = out_res_reg.line_lost;
    assign drive_left  = out_res_reg.drive_left;
    assign drive_right = out_res_reg.drive_right;
    assign pid_output  = out_res_reg.pid_output;

endmodule

// ----- hw/rtl/lfps_mul.sv -----
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module lfps_mul import lfps_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [MCAND_W-1:0]  mcand,
    input  logic signed [MPLIER_W-1:0] mplier,
    output logic                       done,
    output logic signed [PROD_W-1:0]   product
);

    localparam int STEP_W = $clog2(MPLIER_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MPLIER_W - 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [PROD_W-1:0]   mcand_reg;
    logic [MPLIER_W-1:0]        mplier_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]   addend;
    logic signed [PROD_W-1:0]   acc_next;

    // Pick the partial product; the top bit carries negative weight
    always_comb
    begin
        addend = mplier_reg[0] ? mcand_reg : '0;
        if (step_reg == STEP_LAST)
        begin
            acc_next = acc_reg - addend;
        end
        else
        begin
            acc_next = acc_reg + addend;
        end
    end

    // Advance one multiplier bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            acc_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            done_reg   <= 1'b0;
            step_reg   <= '0;
            mcand_reg  <= PROD_W'(mcand);
            mplier_reg <= mplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
            step_reg   <= step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hw/rtl/lfps_div.sv -----
// Restoring divider, one quotient bit per cycle, for the position mean.
module lfps_div import lfps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [CNT_W-1:0]  divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVD_W + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVD_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIVD_W-1:0] num_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        trial = {rem_reg, num_reg[DIVD_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Shift in one dividend bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            num_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
            num_reg  <= dividend;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg  <= {quo_reg[DIVD_W-2:0], fits};
            num_reg  <= num_reg << 1;
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/lfps_core.sv -----
// Sequencer and datapath: sensor scan, position mean, filters, PID and clamps.
module lfps_core import lfps_pkg::*;
#(
    parameter int SENSOR_COUNT = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SENSOR_COUNT-1:0] mask,
    input  cfg_t                    cfg,
    output logic                    idle,
    output logic                    res_valid,
    input  logic                    res_take,
    output result_t                 res
);

    localparam int IDX_W = $clog2(SENSOR_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SENSOR_COUNT - 1);
    localparam logic signed [SUM_W-1:0] WEIGHT_OFS = SUM_W'(SENSOR_COUNT - 1);

    // Divide by a power of two, rounding toward zero
    function automatic logic signed [PROD_W-1:0] shr_trunc(
        input logic signed [PROD_W-1:0] v,
        input logic [3:0]               sh
    );
        logic signed [PROD_W-1:0] bias;
        begin
            bias = (v < 0) ? ((PROD_W'(1) <<< sh) - PROD_W'(1)) : '0;
            return (v + bias) >>> sh;
        end
    endfunction

    // Saturate a Q1.15 coefficient at one
    function automatic logic signed [MPLIER_W-1:0] alpha_sat(input logic [15:0] a);
        begin
            return (a > 16'(ALPHA_ONE)) ? MPLIER_W'(ALPHA_ONE) : $signed({1'b0, a});
        end
    endfunction

    // Clamp a Q8.8 speed to the motor range and drop the fraction
    function automatic logic [6:0] speed_of(input logic signed [25:0] v);
        logic signed [25:0] c;
        begin
            if (v < 26'sd0)
            begin
                c = '0;
            end
            else if (v > 26'(SPEED_MAX_Q))
            begin
                c = 26'(SPEED_MAX_Q);
            end
            else
            begin
                c = v;
            end
            return 7'(c >>> 8);
        end
    endfunction

    state_t                    state_reg;
    state_t                    state_next;
    mul_op_t                   op_reg;
    logic [SENSOR_COUNT-1:0]   mask_sr_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [15:0]        raw_reg;
    logic signed [15:0]        fp_reg;
    logic                      restart_reg;
    logic signed [15:0]        prev_reg;
    logic signed [23:0]        integ_reg;
    logic signed [23:0]        df_reg;
    logic                      was_lost_reg;
    logic signed [23:0]        p_reg;
    logic signed [23:0]        din_reg;
    logic signed [23:0]        ki_reg;
    logic signed [24:0]        i_term_reg;
    logic signed [25:0]        total_reg;
    result_t                   res_reg;

    logic                      hit;
    logic [CNT_W-1:0]          cnt_final;
    logic                      scan_last;
    logic signed [SUM_W-1:0]   weight;
    logic signed [16:0]        err;
    logic [SUM_W-1:0]          sum_abs;
    logic                      div_start;
    logic                      div_done;
    logic [DIVD_W-1:0]         div_quo;
    logic signed [15:0]        raw_calc;
    logic                      mul_start;
    logic                      mul_done;
    logic signed [MCAND_W-1:0] mcand;
    logic signed [MPLIER_W-1:0] mplier;
    logic signed [PROD_W-1:0]  prod;

    logic signed [25:0]        limit;
    logic signed [25:0]        ilim;
    logic signed [25:0]        ki_w;
    logic signed [25:0]        i_term_w;
    logic signed [25:0]        integ_sel;
    logic signed [25:0]        integ_clamped;
    logic signed [25:0]        outv;
    logic signed [25:0]        trim_w;

    // Scan one sensor bit per cycle
    always_comb
    begin
        hit       = mask_sr_reg[0];
        cnt_final = cnt_reg + CNT_W'(hit);
        scan_last = (idx_reg == IDX_LAST);
        weight    = ($signed(SUM_W'(idx_reg) <<< 1) - WEIGHT_OFS) <<< 7;
        err       = -(17'(fp_reg));
        sum_abs   = (sum_reg < 0) ? -sum_reg : sum_reg;
        raw_calc  = sum_reg[SUM_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end

    // Route multiplier operands for the current step
    always_comb
    begin
        case (op_reg)
            OP_POS:
            begin
                mcand  = MCAND_W'(raw_reg) - MCAND_W'(fp_reg);
                mplier = alpha_sat(cfg.position_alpha);
            end
            OP_P:
            begin
                mcand  = MCAND_W'(err);
                mplier = MPLIER_W'(cfg.gain_p);
            end
            OP_D:
            begin
                mcand  = MCAND_W'(err) - MCAND_W'(prev_reg);
                mplier = MPLIER_W'(cfg.gain_d);
            end
            OP_DF:
            begin
                mcand  = din_reg - df_reg;
                mplier = alpha_sat(cfg.derivative_alpha);
            end
            OP_I:
            begin
                mcand  = MCAND_W'(err);
                mplier = MPLIER_W'(cfg.gain_i);
            end
            default:
            begin
                mcand  = '0;
                mplier = '0;
            end
        endcase
    end

    // Saturate the output and hold the integral against windup
    always_comb
    begin
        limit    = $signed(26'({cfg.cruise_speed, 8'b0}));
        ilim     = $signed(26'(cfg.integral_limit));
        ki_w     = 26'(ki_reg);
        i_term_w = 26'(i_term_reg);
        trim_w   = 26'(cfg.trim_offset);
        if (total_reg > limit)
        begin
            integ_sel = (ki_w > 26'sd0) ? 26'(integ_reg) : i_term_w;
            outv      = limit;
        end
        else if (total_reg < -limit)
        begin
            integ_sel = (ki_w < 26'sd0) ? 26'(integ_reg) : i_term_w;
            outv      = -limit;
        end
        else
        begin
            integ_sel = i_term_w;
            outv      = total_reg;
        end
        if (integ_sel > ilim)
        begin
            integ_clamped = ilim;
        end
        else if (integ_sel < -ilim)
        begin
            integ_clamped = -ilim;
        end
        else
        begin
            integ_clamped = integ_sel;
        end
    end

    lfps_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_abs[DIVD_W-1:0]),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    lfps_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mcand),
        .mplier  (mplier),
        .done    (mul_done),
        .product (prod)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = (cnt_final == '0) ? ST_DONE : ST_DIV_GO;
                end
            end
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_MUL_GO;
            ST_MUL_GO:   state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (op_reg == OP_I) ? ST_SUM : ST_MUL_GO;
                end
            end
            ST_SUM:      state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_DONE;
            ST_DONE:     if (res_take) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        idle      = 1'b0;
        div_start = 1'b0;
        mul_start = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:   idle      = 1'b1;
            ST_DIV_GO: div_start = 1'b1;
            ST_MUL_GO: mul_start = 1'b1;
            ST_DONE:   res_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= OP_POS;
            mask_sr_reg  <= '0;
            idx_reg      <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            raw_reg      <= '0;
            fp_reg       <= '0;
            restart_reg  <= 1'b1;
            prev_reg     <= '0;
            integ_reg    <= '0;
            df_reg       <= '0;
            was_lost_reg <= 1'b0;
            p_reg        <= '0;
            din_reg      <= '0;
            ki_reg       <= '0;
            i_term_reg   <= '0;
            total_reg    <= '0;
            res_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        mask_sr_reg <= mask;
                        idx_reg     <= '0;
                        sum_reg     <= '0;
                        cnt_reg     <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (hit)
                    begin
                        sum_reg <= sum_reg + weight;
                    end
                    cnt_reg     <= cnt_final;
                    mask_sr_reg <= mask_sr_reg >> 1;
                    idx_reg     <= idx_reg + 1'b1;
                    if (scan_last)
                    begin
                        if (cnt_final == '0)
                        begin
                            // Line lost: stop the motors, remember it
                            was_lost_reg <= 1'b1;
                            res_reg      <= '{line_lost: 1'b1, drive_left: '0,
                                              drive_right: '0, pid_output: '0};
                        end
                        else if (was_lost_reg)
                        begin
                            // Line found again: drop the controller history
                            integ_reg    <= '0;
                            df_reg       <= '0;
                            prev_reg     <= '0;
                            restart_reg  <= 1'b1;
                            was_lost_reg <= 1'b0;
                        end
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (restart_reg)
                        begin
                            fp_reg      <= raw_calc;
                            restart_reg <= 1'b0;
                            op_reg      <= OP_P;
                        end
                        else
                        begin
                            raw_reg <= raw_calc;
                            op_reg  <= OP_POS;
                        end
                    end
                end
                ST_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        case (op_reg)
                            OP_POS:
                            begin
                                fp_reg <= 16'(shr_trunc(prod + (PROD_W'(fp_reg) <<< 15), 4'd15));
                                op_reg <= OP_P;
                            end
                            OP_P:
                            begin
                                p_reg  <= 24'(shr_trunc(prod, 4'd8));
                                op_reg <= OP_D;
                            end
                            OP_D:
                            begin
                                din_reg <= 24'(shr_trunc(prod, 4'd8));
                                op_reg  <= OP_DF;
                            end
                            OP_DF:
                            begin
                                df_reg <= 24'(shr_trunc(prod + (PROD_W'(df_reg) <<< 15), 4'd15));
                                op_reg <= OP_I;
                            end
                            OP_I:
                            begin
                                ki_reg <= 24'(shr_trunc(prod, 4'd8));
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SUM:
                begin
                    i_term_reg <= 25'(integ_reg) + 25'(ki_reg);
                    total_reg  <= 26'(p_reg) + 26'(integ_reg) + 26'(ki_reg) + 26'(df_reg);
                end
                ST_CLAMP:
                begin
                    integ_reg <= 24'(integ_clamped);
                    prev_reg  <= 16'(err);
                    res_reg   <= '{line_lost: 1'b0,
                                   drive_left: speed_of(limit - outv + trim_w),
                                   drive_right: speed_of(limit + outv - trim_w),
                                   pid_output: 16'(outv)};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

// ----- hw/rtl/lfps_checker.sv -----
// Port-level checks for the line-follow PID steering block, bound to the top.
module lfps_checker import lfps_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [MASK_W-1:0]      sensor_mask,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   line_lost,
    input logic [6:0]             drive_left,
    input logic [6:0]             drive_right,
    input logic signed [15:0]     pid_output
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pid_output)
            && $stable(drive_left) && $stable(drive_right) && $stable(line_lost))
        else $error("result changed while stalled");

    // Lost line stops the motors
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_lost |-> drive_left == 7'd0 && drive_right == 7'd0
            && pid_output == 16'sd0)
        else $error("lost line with nonzero drive");

    // Speeds stay in the motor range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drive_left <= 7'd100 && drive_right <= 7'd100)
        else $error("speed out of range");

    // One request in flight: ready drops after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (.*);

// ----- sim/line_follow_pid_steering_test.sv -----
// Testbench for the line-follow PID steering block: random and directed masks, scoreboarded.
`timescale 1ns / 100ps

module line_follow_pid_steering_test;
    import lfps_pkg::*;

    localparam int NSENS = 12;

    // Expected result and steering predictor with its own state
    class steering_scoreboard;
        result_t     expected_q[$];
        int          errors;
        logic [15:0] kp, ki, kd, trim, palpha, dalpha;
        logic [6:0]  base;
        logic [14:0] ilimit;
        longint      filt_pos, prev_err, integ, deriv;
        bit          restart, lost;

        function new();
            kp = 16'd256; ki = 16'd0; kd = 16'd128; base = 7'd50; trim = 16'd0;
            palpha = 16'd6554; dalpha = 16'd3277; ilimit = 15'd7680;
            filt_pos = 0; prev_err = 0; integ = 0; deriv = 0;
            restart = 1'b1; lost = 1'b0; errors = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] val);
            case (idx)
                REG_GAIN_P:           kp = val;
                REG_GAIN_I:           ki = val;
                REG_GAIN_D:           kd = val;
                REG_BASE_SPEED:       base = val[6:0];
                REG_TRIM_OFFSET:      trim = val;
                REG_POSITION_ALPHA:   palpha = val;
                REG_DERIVATIVE_ALPHA: dalpha = val;
                REG_INTEGRAL_LIMIT:   ilimit = val[14:0];
                default: ;
            endcase
        endfunction

        function longint sat_alpha(logic [15:0] a);
            return (a > ALPHA_ONE) ? ALPHA_ONE : longint'(a);
        endfunction

        function longint mix(longint a, longint x, longint y);
            return (a * x + (ALPHA_ONE - a) * y) / ALPHA_ONE;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Note an accepted sensor request and queue its result
        function void note_request(logic [MASK_W-1:0] mask);
            result_t r;
            longint  sum, cnt, raw, err, p, kie, iterm, total, lim, nint, outv, lq, rq;
            sum = 0; cnt = 0;
            for (int i = 0; i < NSENS; i++)
                if (mask[i])
                begin
                    sum += (2 * i - (NSENS - 1)) * 128;
                    cnt++;
                end
            if (cnt == 0)
            begin
                lost = 1'b1;
                r = '0;
                r.line_lost = 1'b1;
                expected_q.push_back(r);
                return;
            end
            if (lost)
            begin
                integ = 0; deriv = 0; prev_err = 0; restart = 1'b1; lost = 1'b0;
            end
            raw = sum / cnt;
            if (restart)
            begin
                filt_pos = raw;
                restart = 1'b0;
            end
            else
                filt_pos = mix(sat_alpha(palpha), raw, filt_pos);
            err = -filt_pos;
            p = longint'($signed(kp)) * err / 256;
            deriv = mix(sat_alpha(dalpha), longint'($signed(kd)) * (err - prev_err) / 256,
                        deriv);
            kie = longint'($signed(ki)) * err / 256;
            iterm = integ + kie;
            total = p + iterm + deriv;
            lim = longint'(base) * 256;
            nint = integ;
            if (total > lim)
            begin
                if (!(kie > 0)) nint = iterm;
                outv = lim;
            end
            else if (total < -lim)
            begin
                if (!(kie < 0)) nint = iterm;
                outv = -lim;
            end
            else
            begin
                nint = iterm;
                outv = total;
            end
            integ = clip(nint, -longint'(ilimit), longint'(ilimit));
            prev_err = err;
            lq = clip(lim - outv + longint'($signed(trim)), 0, SPEED_MAX_Q) / 256;
            rq = clip(lim + outv - longint'($signed(trim)), 0, SPEED_MAX_Q) / 256;
            r.line_lost   = 1'b0;
            r.drive_left  = lq[6:0];
            r.drive_right = rq[6:0];
            r.pid_output  = outv[15:0];
            expected_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(result_t got);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.line_lost !== e.line_lost)
            begin
                $display("%0t: line_lost exp %0d got %0d", $time, e.line_lost, got.line_lost);
                errors++;
            end
            if (got.drive_left !== e.drive_left)
            begin
                $display("%0t: drive_left exp %0d got %0d", $time, e.drive_left,
                         got.drive_left);
                errors++;
            end
            if (got.drive_right !== e.drive_right)
            begin
                $display("%0t: drive_right exp %0d got %0d", $time, e.drive_right,
                         got.drive_right);
                errors++;
            end
            if (got.pid_output !== e.pid_output)
            begin
                $display("%0t: pid_output exp %0d got %0d", $time, e.pid_output,
                         got.pid_output);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [MASK_W-1:0]      sensor_mask;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   out_valid;
    logic                   out_ready;
    logic                   line_lost;
    logic [6:0]             drive_left;
    logic [6:0]             drive_right;
    logic signed [15:0]     pid_output;

    steering_scoreboard sb;
    bit                 quiet_rx;
    bit                 hold_rx;

    line_follow_pid_steering #(.SENSOR_COUNT(NSENS)) u_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Send one sensor request and wait for it to be accepted
    task automatic send_mask(logic [MASK_W-1:0] mask);
        in_valid    <= 1'b1;
        sensor_mask <= mask;
        do @(posedge clk); while (!in_ready);
        sb.note_request(mask);
        @(negedge clk);
        in_valid <= 1'b0;
        // Hold valid low for one cycle before the next request
        @(negedge clk);
    endtask

    task automatic send_random_gap(logic [MASK_W-1:0] mask);
        int gap;
        gap = quiet_rx ? 0 : $urandom_range(0, 16);
        repeat (gap) @(negedge clk);
        send_mask(mask);
    endtask

    // Wait until every expected result has come and the block is idle
    task automatic drain();
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (160) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        // Hold valid low for one cycle before the next write
        @(negedge clk);
    endtask

    // Mostly short runs of one line position, some lost-line gaps
    function automatic logic [MASK_W-1:0] pick_mask();
        int k, w;
        logic [MASK_W-1:0] m;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k < 3) return MASK_W'($urandom);
        w = $urandom_range(1, 3);
        m = MASK_W'((1 << w) - 1);
        return m << $urandom_range(0, NSENS - w);
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_random_gap(pick_mask());
    endtask

    task automatic random_config();
        write_reg(REG_GAIN_P, 16'($urandom_range(0, 1024)) - 16'd256);
        write_reg(REG_GAIN_I, 16'($urandom_range(0, 128)) - 16'd32);
        write_reg(REG_GAIN_D, 16'($urandom_range(0, 1024)) - 16'd256);
        write_reg(REG_BASE_SPEED, 16'($urandom_range(0, 127)));
        write_reg(REG_TRIM_OFFSET, 16'($urandom_range(0, 4096)) - 16'd2048);
        write_reg(REG_POSITION_ALPHA, 16'($urandom_range(0, 65535)));
        write_reg(REG_DERIVATIVE_ALPHA, 16'($urandom_range(0, 65535)));
        write_reg(REG_INTEGRAL_LIMIT, 16'($urandom_range(0, 32767)));
    endtask

    // Receiver: random stalls, plus a long hold-off while sender runs
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                repeat (600) @(negedge clk);
                hold_rx = 0;
            end
            stall = quiet_rx ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Sample results at the rising edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result('{line_lost, drive_left, drive_right, pid_output});

    initial
    begin
        #30ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        sb = new();
        clk = 1'b0; rst_n = 1'b0;
        in_valid = 1'b0; sensor_mask = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        quiet_rx = 0; hold_rx = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: defaults, single edges, full mask, lost and found again
        send_mask(12'h001);
        send_mask(12'h800);
        send_mask(12'hFFF);
        send_mask(12'h000);
        send_mask(12'h000);
        send_mask(12'h060);
        send_mask(12'hAAA);
        send_mask(12'h555);
        drain();

        // Extreme settings: saturating gains, alpha above one, base above range
        write_reg(REG_GAIN_P, 16'h7FFF);
        write_reg(REG_GAIN_I, 16'h7FFF);
        write_reg(REG_GAIN_D, 16'h8000);
        write_reg(REG_BASE_SPEED, 16'd127);
        write_reg(REG_TRIM_OFFSET, 16'd25600);
        write_reg(REG_POSITION_ALPHA, 16'hFFFF);
        write_reg(REG_DERIVATIVE_ALPHA, 16'd32768);
        write_reg(REG_INTEGRAL_LIMIT, 16'h7FFF);
        send_mask(12'h001);
        send_mask(12'h800);
        send_mask(12'h003);
        send_mask(12'hC00);
        drain();
        write_reg(REG_GAIN_P, 16'h8000);
        write_reg(REG_GAIN_I, 16'h8000);
        write_reg(REG_GAIN_D, 16'h7FFF);
        write_reg(REG_BASE_SPEED, 16'd0);
        write_reg(REG_TRIM_OFFSET, 16'hFFFF - 16'd25599);
        write_reg(REG_POSITION_ALPHA, 16'd0);
        write_reg(REG_DERIVATIVE_ALPHA, 16'd0);
        write_reg(REG_INTEGRAL_LIMIT, 16'd0);
        send_mask(12'h800);
        send_mask(12'h001);
        send_mask(12'h000);
        send_mask(12'h100);
        drain();
        write_reg(REG_BASE_SPEED, 16'd100);
        write_reg(REG_GAIN_P, 16'd300);
        write_reg(REG_GAIN_I, 16'd40);
        write_reg(REG_GAIN_D, 16'd200);
        write_reg(REG_TRIM_OFFSET, 16'd0);
        write_reg(REG_POSITION_ALPHA, 16'd16384);
        write_reg(REG_DERIVATIVE_ALPHA, 16'd8192);
        write_reg(REG_INTEGRAL_LIMIT, 16'd3000);
        send_mask(12'h001);
        send_mask(12'h001);
        send_mask(12'h001);

        // Fill the block while the receiver holds off
        hold_rx = 1;
        random_phase(6);
        drain();

        // Random phases with new settings, one with no idling
        for (int ph = 0; ph < 8; ph++)
        begin
            random_config();
            quiet_rx = (ph == 3);
            random_phase(175);
            drain();
        end
        quiet_rx = 0;

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- line_follow_pid_steering.f -----
hw/rtl/lfps_pkg.sv
hw/rtl/lfps_mul.sv
hw/rtl/lfps_div.sv
hw/rtl/lfps_core.sv
hw/rtl/line_follow_pid_steering.sv
hw/rtl/lfps_checker.sv
sim/line_follow_pid_steering_test.sv
